// ===== design/mfv_pkg.sv =====
package mfv_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned SIZE_W = 25;

   // request kinds carried in req_tuser
   localparam logic OP_START = 1'b0;
   localparam logic OP_DONE  = 1'b1;

   // configuration register indexes
   localparam logic REG_BASE = 1'b0;
   localparam logic REG_SIZE = 1'b1;

   localparam logic [2:0] PHASE_FIRST   = 3'd0;
   localparam logic [2:0] PHASE_WORD_UP = 3'd4;
   localparam logic [2:0] PHASE_LAST    = 3'd5;

   localparam logic [DATA_W-1:0] PAT_STEP_UP   = 32'd37;
   localparam logic [DATA_W-1:0] PAT_STEP_DOWN = 32'd319993;

   localparam logic [1:0] EV_NONE        = 2'd0;
   localparam logic [1:0] EV_FILL_DONE   = 2'd1;
   localparam logic [1:0] EV_VERIFY_PASS = 2'd2;

   localparam logic [1:0] STATUS_IDLE    = 2'd0;
   localparam logic [1:0] STATUS_RUNNING = 2'd1;
   localparam logic [1:0] STATUS_PASSED  = 2'd2;
   localparam logic [1:0] STATUS_FAILED  = 2'd3;

   localparam int unsigned RSP_DATA_W = 104;

   typedef enum logic [3:0] {
      RUN_IDLE   = 4'b0001,
      RUN_ACTIVE = 4'b0010,
      RUN_PASS   = 4'b0100,
      RUN_FAIL   = 4'b1000
   } run_state_type;

   typedef enum logic [2:0] {
      ACC_BYTE_WR = 3'd0,
      ACC_BYTE_RD = 3'd1,
      ACC_WORD_WR = 3'd2,
      ACC_WORD_RD = 3'd3,
      ACC_NONE    = 3'd4
   } access_kind_type;

   typedef struct packed {
      run_state_type     run;
      logic [2:0]        phase;
      logic              verifying;
      logic [DATA_W-1:0] pattern;
      logic              pend_read;
      logic [DATA_W-1:0] pend_expected;
      logic [DATA_W-1:0] pend_addr;
      logic [DATA_W-1:0] fail_addr;
      logic [DATA_W-1:0] base;
   } core_type;

   typedef struct packed {
      access_kind_type   kind;
      logic [DATA_W-1:0] addr;
      logic [DATA_W-1:0] wdata;
      logic [2:0]        phase;
      logic [1:0]        phase_event;
      logic [1:0]        status;
      logic [DATA_W-1:0] fail_addr;
   } result_type;

   function automatic logic [DATA_W-1:0] phase_start(input logic [2:0] phase);
      logic [DATA_W-1:0] value;
      unique case (phase)
         3'd0:    value = 32'h0000_0000;
         3'd1:    value = 32'h0000_00FF;
         3'd2:    value = 32'h0000_00AA;
         3'd3:    value = 32'h0000_0055;
         3'd4:    value = 32'h0000_0000;
         default: value = 32'hFEDC_BA98;
      endcase
      return value;
   endfunction

   function automatic logic [1:0] status_code(input run_state_type run);
      logic [1:0] code;
      unique case (run)
         RUN_ACTIVE: code = STATUS_RUNNING;
         RUN_PASS:   code = STATUS_PASSED;
         RUN_FAIL:   code = STATUS_FAILED;
         default:    code = STATUS_IDLE;
      endcase
      return code;
   endfunction

endpackage

// ===== design/mfv_step.sv =====
module mfv_step
   import mfv_pkg::*;
#(
   parameter int unsigned OFFSET_BITS = 24,
   localparam int unsigned CNT_W = OFFSET_BITS + 1
) (
   input  logic              op,
   input  logic [DATA_W-1:0] read_data,
   input  logic [DATA_W-1:0] cfg_base,
   input  logic [SIZE_W-1:0] cfg_size,
   input  core_type          cur,
   input  logic [CNT_W-1:0]  cur_offset,
   input  logic [CNT_W-1:0]  cur_size,
   output core_type          nxt,
   output logic [CNT_W-1:0]  nxt_offset,
   output logic [CNT_W-1:0]  nxt_size,
   output result_type        res
);

   localparam int unsigned SAT_W = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;
   localparam logic [SAT_W-1:0] SIZE_LIMIT = SAT_W'(1) << OFFSET_BITS;

   logic [SAT_W-1:0]  size_wide;
   logic [CNT_W-1:0]  size_sat;
   logic              miscompare;
   logic              go;
   logic              word;
   logic [1:0]        ev;
   logic [DATA_W-1:0] issue_addr;

   always_comb begin
      size_wide = SAT_W'(cfg_size);
      size_sat  = (size_wide > SIZE_LIMIT) ? CNT_W'(SIZE_LIMIT) : CNT_W'(size_wide);
   end

   // byte phases only check the low lane
   assign miscompare = (cur.phase < PHASE_WORD_UP)
                     ? (read_data[7:0] != cur.pend_expected[7:0])
                     : (read_data != cur.pend_expected);

   always_comb begin
      nxt        = cur;
      nxt_offset = cur_offset;
      nxt_size   = cur_size;
      ev         = EV_NONE;
      go         = 1'b0;

      if (op == OP_START) begin
         nxt.base          = cfg_base;
         nxt_size          = size_sat;
         nxt.phase         = PHASE_FIRST;
         nxt.verifying     = 1'b0;
         nxt.pend_read     = 1'b0;
         nxt.pend_expected = '0;
         nxt.pend_addr     = '0;
         nxt.fail_addr     = '0;
         nxt_offset        = '0;
         nxt.pattern       = phase_start(PHASE_FIRST);
         if (size_sat == '0) begin
            nxt.run = RUN_PASS;
         end else begin
            nxt.run = RUN_ACTIVE;
            go      = 1'b1;
         end
      end else if (cur.run == RUN_ACTIVE) begin
         go = 1'b1;
         if (cur.pend_read) begin
            nxt.pend_read = 1'b0;
            if (miscompare) begin
               nxt.run       = RUN_FAIL;
               nxt.fail_addr = cur.pend_addr;
               go            = 1'b0;
            end
         end
         if (go && (cur_offset >= cur_size)) begin
            nxt_offset  = '0;
            if (!cur.verifying) begin
               nxt.verifying = 1'b1;
               ev            = EV_FILL_DONE;
               nxt.pattern   = phase_start(cur.phase);
            end else begin
               ev = EV_VERIFY_PASS;
               if (cur.phase >= PHASE_LAST) begin
                  nxt.run = RUN_PASS;
                  go      = 1'b0;
               end else begin
                  nxt.phase     = cur.phase + 3'd1;
                  nxt.verifying = 1'b0;
                  nxt.pattern   = phase_start(cur.phase + 3'd1);
               end
            end
         end
      end

      // access for this transaction, built from the updated position
      word       = (nxt.phase >= PHASE_WORD_UP);
      issue_addr = nxt.base + DATA_W'(nxt_offset);
      res.kind   = ACC_NONE;
      res.addr   = '0;
      res.wdata  = '0;
      if (go) begin
         res.addr = issue_addr;
         if (nxt.verifying) begin
            res.kind          = word ? ACC_WORD_RD : ACC_BYTE_RD;
            nxt.pend_read     = 1'b1;
            nxt.pend_expected = nxt.pattern;
            nxt.pend_addr     = issue_addr;
         end else begin
            res.kind  = word ? ACC_WORD_WR : ACC_BYTE_WR;
            res.wdata = nxt.pattern;
         end
         if (word) begin
            nxt_offset = nxt_offset + CNT_W'(4);
            if (nxt.phase == PHASE_WORD_UP) begin
               nxt.pattern = nxt.pattern + PAT_STEP_UP;
            end else begin
               nxt.pattern = nxt.pattern - PAT_STEP_DOWN;
            end
         end else begin
            nxt_offset = nxt_offset + CNT_W'(1);
         end
      end

      res.phase       = nxt.phase;
      res.phase_event = ev;
      res.status      = status_code(nxt.run);
      res.fail_addr   = nxt.fail_addr;
   end

endmodule

// ===== design/memory_fill_verify_test_sequencer.sv =====
// channel   | direction | handshake              | payload
// ----------+-----------+------------------------+-----------------------------------------
// req_      | in        | req_tvalid/req_tready  | tuser op, tdata read_data
// rsp_      | out       | rsp_tvalid/rsp_tready  | tuser access_kind, tdata access + status
// csr_      | in        | csr_valid/csr_ready    | csr_index, csr_data
//
// one request transaction per cycle unless stalled; its response enters the output register
// next cycle, by the single offset/pattern/compare step between state and result register.
// reset (synchronous, active high) returns the test to idle, base 0 and size 1.
// a response stalled by rsp_tready holds req_tready low until it is taken;
// csr writes complete every cycle and take effect at the next start.
module memory_fill_verify_test_sequencer
   import mfv_pkg::*;
#(
   parameter int unsigned OFFSET_BITS = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [DATA_W-1:0]     req_tdata,   // [31:0] read_data
   input  logic                  req_tuser,   // [0] op
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [31:0] address, [63:32] write_data, [66:64] phase, [68:67] phase_event,
   // [70:69] status, [102:71] fail_address, [103] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [2:0]            rsp_tuser,   // [2:0] access_kind
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [DATA_W-1:0]     csr_data
);

   localparam int unsigned CNT_W = OFFSET_BITS + 1;

   logic [DATA_W-1:0]     cfg_base_ff;
   logic [SIZE_W-1:0]     cfg_size_ff;
   core_type              core_ff;
   core_type              core_in;
   logic [CNT_W-1:0]      offset_ff;
   logic [CNT_W-1:0]      offset_in;
   logic [CNT_W-1:0]      size_ff;
   logic [CNT_W-1:0]      size_in;
   result_type            res;
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [2:0]            rsp_user_ff;
   logic                  req_accept;

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_base_ff <= '0;
         cfg_size_ff <= SIZE_W'(1);
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_BASE: cfg_base_ff <= csr_data;
            REG_SIZE: cfg_size_ff <= csr_data[SIZE_W-1:0];
         endcase
      end
   end

   mfv_step #(
      .OFFSET_BITS(OFFSET_BITS)
   ) u_step (
      .op         (req_tuser),
      .read_data  (req_tdata),
      .cfg_base   (cfg_base_ff),
      .cfg_size   (cfg_size_ff),
      .cur        (core_ff),
      .cur_offset (offset_ff),
      .cur_size   (size_ff),
      .nxt        (core_in),
      .nxt_offset (offset_in),
      .nxt_size   (size_in),
      .res        (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         core_ff <= '{run: RUN_IDLE, phase: PHASE_FIRST, verifying: 1'b0,
                      pattern: '0, pend_read: 1'b0, pend_expected: '0,
                      pend_addr: '0, fail_addr: '0, base: '0};
         offset_ff <= '0;
         size_ff   <= '0;
      end else if (req_accept) begin
         core_ff   <= core_in;
         offset_ff <= offset_in;
         size_ff   <= size_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= {1'b0, res.fail_addr, res.status, res.phase_event, res.phase,
                         res.wdata, res.addr};
         rsp_user_ff <= res.kind;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ===== design/mfv_checker.sv =====
module mfv_checker
   import mfv_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic req_accept;
   assign req_accept = req_tvalid && req_tready;

   // a stalled response holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // every request transaction yields a response in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_tvalid)
      else $error("request without response");

   // a start always leaves the test running or already passed
   assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_tuser == OP_START) |=>
         (rsp_tdata[70:69] == STATUS_RUNNING) || (rsp_tdata[70:69] == STATUS_PASSED))
      else $error("start gave wrong status");

   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind memory_fill_verify_test_sequencer mfv_checker u_mfv_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
